@@ sv/jkve_pkg.sv @@
// Shared constants, codes and types for the JSON key/value extractor.
// Depends on nothing; every other file of the block uses it.
package jkve_pkg;

	// Window and key sizes
	localparam int MAX_KEY_BYTES = 16;
	localparam int KEY_CHARS     = 16;
	localparam int KEY_IDX_W     = 4;
	localparam int FILL_W        = $clog2(MAX_KEY_BYTES + 1);
	localparam int KEY_LEN_W     = 5;

	// Value length counter
	localparam int LENGTH_BITS = 16;
	localparam int VLEN_W      = 16;
	localparam logic [VLEN_W-1:0] COUNT_LIMIT = (LENGTH_BITS >= VLEN_W) ?
		{VLEN_W{1'b1}} : VLEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

	// Decoupling queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_BYTE     = 2'd0;
	localparam logic [1:0] ST_FOUND    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_UNTERM   = 2'd3;

	// Characters of interest
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	// One classified input: a first result and an optional second one
	typedef struct packed {
		logic [1:0]        st_a;
		logic [7:0]        byte_a;
		logic [VLEN_W-1:0] count;
		logic              has_b;
		logic [1:0]        st_b;
	} jkve_entry_t;

	// Front to queue push
	typedef struct packed {
		logic        push;
		jkve_entry_t entry;
	} jkve_push_t;

endpackage

@@ sv/jkve_if.sv @@
// Channel interfaces of the extractor: text input, result output, config writes.
// Depends on jkve_pkg for field widths.
interface jkve_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jkve_result_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [7:0]                  value_byte;
	logic [jkve_pkg::VLEN_W-1:0] value_length;
	logic                        last_of_run;

	modport source (output valid, output status, output value_byte, output value_length,
		output last_of_run, input ready);
	modport sink (input valid, input status, input value_byte, input value_length,
		input last_of_run, output ready);
endinterface

interface jkve_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [jkve_pkg::CFG_IDX_W-1:0] index;
	logic [63:0]                    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/json_key_value_extractor.sv @@
// Channel   Role    Fields
// text      sink    text_byte[7:0], end_of_text
// result    source  status[1:0], value_byte[7:0], value_length[15:0], last_of_run
// cfg       sink    index[1:0] (0 key low, 1 key high, 2 key length), data[63:0]
//
// One text byte is taken per cycle while the queue has room. A byte yields at most
// two results, sent one per cycle from the result register while result.ready is high;
// a four-entry queue absorbs the bursts. Results pass the queue, then that register.
// arst_n clears the key to zero, length one, and all per-text state.
// Text stalls only when the queue is full; config writes are always taken.
// Top level: front end, decoupling queue and back end. Depends on jkve_pkg, jkve_if.
module json_key_value_extractor (
	input  logic          clk,
	input  logic          arst_n,
	jkve_text_if.sink     text,
	jkve_cfg_if.sink      cfg,
	jkve_result_if.source result
);
	import jkve_pkg::*;

	jkve_push_t  push;
	jkve_entry_t q_entry;
	logic        q_in_ready;
	logic        q_valid;
	logic        q_pop;

	// Accept and classify
	jkve_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text),
		.cfg     (cfg),
		.q_ready (q_in_ready),
		.push    (push)
	);

	// Decouple the two sides
	jkve_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_ready  (q_in_ready),
		.out_valid (q_valid),
		.out_entry (q_entry),
		.pop       (q_pop)
	);

	// Emit results
	jkve_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule

@@ sv/jkve_front.sv @@
// Front end: config registers, byte window, key match and phase tracking.
// Classifies each accepted byte into a queue entry. Depends on jkve_pkg, jkve_if.
module jkve_front (
	input  logic                  clk,
	input  logic                  arst_n,
	jkve_text_if.sink             text,
	jkve_cfg_if.sink              cfg,
	input  logic                  q_ready,
	output jkve_pkg::jkve_push_t  push
);
	import jkve_pkg::*;

	localparam logic [2:0] PH_KEY   = 3'd0;
	localparam logic [2:0] PH_COLON = 3'd1;
	localparam logic [2:0] PH_OPEN  = 3'd2;
	localparam logic [2:0] PH_VALUE = 3'd3;
	localparam logic [2:0] PH_DONE  = 3'd4;

	logic [63:0]          key_low_q;
	logic [63:0]          key_high_q;
	logic [KEY_LEN_W-1:0] key_len_q;
	logic [7:0]           win_q [MAX_KEY_BYTES];
	logic [7:0]           win_nxt [MAX_KEY_BYTES];
	logic [FILL_W-1:0]    fill_q;
	logic [FILL_W-1:0]    fill_nxt;
	logic [2:0]           phase_q;
	logic [2:0]           phase_nxt;
	logic [VLEN_W-1:0]    count_q;
	logic [VLEN_W-1:0]    count_nxt;
	logic [KEY_LEN_W-1:0] elen;
	logic [8*KEY_CHARS-1:0] key_vec;
	logic                 match;
	logic                 accept;
	logic                 a_valid;
	logic [1:0]           a_st;
	logic [7:0]           a_byte;
	logic                 e_valid;
	logic [1:0]           e_st;

	assign accept    = text.valid & text.ready;
	assign text.ready = q_ready;
	assign cfg.ready = 1'b1;
	assign key_vec   = {key_high_q, key_low_q};

	// Clamp the key length into 1..MAX_KEY_BYTES
	always_comb begin
		if (key_len_q == '0) begin
			elen = KEY_LEN_W'(1);
		end else if (key_len_q > KEY_LEN_W'(MAX_KEY_BYTES)) begin
			elen = KEY_LEN_W'(MAX_KEY_BYTES);
		end else begin
			elen = key_len_q;
		end
	end

	// Shift the new byte into the window and compare every slot in parallel
	always_comb begin
		logic [KEY_LEN_W-1:0] kidx;
		win_nxt[0] = text.text_byte;
		for (int j = 1; j < MAX_KEY_BYTES; j++) begin
			win_nxt[j] = win_q[j-1];
		end
		fill_nxt = (fill_q < FILL_W'(MAX_KEY_BYTES)) ? fill_q + FILL_W'(1) : fill_q;
		match = (KEY_LEN_W'(fill_nxt) >= elen);
		for (int j = 0; j < MAX_KEY_BYTES; j++) begin
			kidx = elen - KEY_LEN_W'(1) - KEY_LEN_W'(j);
			if ((KEY_LEN_W'(j) < elen) &&
				(win_nxt[j] != key_vec[8*kidx[KEY_IDX_W-1:0] +: 8])) begin
				match = 1'b0;
			end
		end
	end

	// Advance the phase and classify the byte
	always_comb begin
		phase_nxt = phase_q;
		count_nxt = count_q;
		a_valid   = 1'b0;
		a_st      = ST_BYTE;
		a_byte    = 8'd0;
		case (phase_q)
			PH_KEY: begin
				if (match) phase_nxt = PH_COLON;
			end
			PH_COLON: begin
				if (text.text_byte == CH_COLON) phase_nxt = PH_OPEN;
			end
			PH_OPEN: begin
				if (text.text_byte == CH_QUOTE) phase_nxt = PH_VALUE;
			end
			PH_VALUE: begin
				a_valid = 1'b1;
				if (text.text_byte == CH_QUOTE) begin
					a_st      = ST_FOUND;
					phase_nxt = PH_DONE;
				end else begin
					if (count_q < COUNT_LIMIT) count_nxt = count_q + VLEN_W'(1);
					a_byte = text.text_byte;
				end
			end
			default: begin
			end
		endcase
		e_valid = text.end_of_text && (phase_nxt != PH_DONE);
		e_st    = (phase_nxt == PH_VALUE) ? ST_UNTERM : ST_NOTFOUND;
	end

	// Pack the results; a lone end-of-text result goes in the first slot
	always_comb begin
		push.push         = accept & (a_valid | e_valid);
		push.entry.count  = count_nxt;
		push.entry.has_b  = a_valid & e_valid;
		push.entry.st_b   = e_st;
		push.entry.st_a   = a_valid ? a_st : e_st;
		push.entry.byte_a = a_valid ? a_byte : 8'd0;
	end

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			key_len_q  <= KEY_LEN_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_KEY_LOW:  key_low_q  <= cfg.data;
				REG_KEY_HIGH: key_high_q <= cfg.data;
				REG_KEY_LEN:  key_len_q  <= cfg.data[KEY_LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Text state: clear at the end of each text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_KEY_BYTES; j++) win_q[j] <= 8'd0;
			fill_q  <= '0;
			phase_q <= PH_KEY;
			count_q <= '0;
		end else if (accept) begin
			if (text.end_of_text) begin
				for (int j = 0; j < MAX_KEY_BYTES; j++) win_q[j] <= 8'd0;
				fill_q  <= '0;
				phase_q <= PH_KEY;
				count_q <= '0;
			end else begin
				win_q   <= win_nxt;
				fill_q  <= fill_nxt;
				phase_q <= phase_nxt;
				count_q <= count_nxt;
			end
		end
	end

	a_count_only_in_value: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_KEY || phase_q == PH_COLON || phase_q == PH_OPEN) |-> count_q == '0)
		else $error("value count set outside the value");

	a_value_needs_key: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_COLON) |-> fill_q != '0)
		else $error("key matched on an empty window");

endmodule

@@ sv/jkve_queue.sv @@
// Short queue between front and back end, holding classified entries.
// Depends on jkve_pkg.
module jkve_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  jkve_pkg::jkve_push_t  push,
	output logic                  in_ready,
	output logic                  out_valid,
	output jkve_pkg::jkve_entry_t out_entry,
	input  logic                  pop
);
	import jkve_pkg::*;

	jkve_entry_t       mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign in_ready  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_entry = mem_q[rd_q];
	assign do_pop    = pop & out_valid;

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push.push) mem_q[wr_q] <= push.entry;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.push) wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			if (do_pop) rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			case ({push.push, do_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |-> in_ready)
		else $error("push into a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_q == rd_q))
		else $error("empty queue with pointers apart");

endmodule

@@ sv/jkve_back.sv @@
// Back end: expands each queue entry into one or two results in an output register.
// Depends on jkve_pkg, jkve_if.
module jkve_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  jkve_pkg::jkve_entry_t q_entry,
	output logic                  q_pop,
	jkve_result_if.source         result
);
	import jkve_pkg::*;

	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [7:0]        byte_q;
	logic [VLEN_W-1:0] len_q;
	logic              last_q;
	logic              pend_q;
	logic [1:0]        pend_st_q;
	logic              load;

	assign load  = !out_valid_q || result.ready;
	assign q_pop = load && !pend_q && q_valid;

	assign result.valid        = out_valid_q;
	assign result.status       = status_q;
	assign result.value_byte   = byte_q;
	assign result.value_length = len_q;
	assign result.last_of_run  = last_q;

	// Output control: second result first, then the next entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else begin
				out_valid_q <= q_valid;
				pend_q      <= q_valid && q_entry.has_b;
			end
		end
	end

	// Output payload; the length is shared by both results of an entry
	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				status_q <= pend_st_q;
				byte_q   <= 8'd0;
				last_q   <= 1'b1;
			end else if (q_valid) begin
				status_q  <= q_entry.st_a;
				byte_q    <= q_entry.byte_a;
				len_q     <= q_entry.count;
				last_q    <= !q_entry.has_b;
				pend_st_q <= q_entry.st_b;
			end
		end
	end

	a_pend_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> out_valid_q)
		else $error("second result pending without a first");

	a_pend_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !last_q)
		else $error("first result marked last while a second is due");

	a_no_pop_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !q_pop)
		else $error("entry taken before the second result went out");

endmodule

@@ test/json_key_value_extractor_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for json_key_value_extractor: directed table, then random JSON texts.
// Depends on jkve_pkg, the jkve_if channel interfaces and the extractor RTL.
module json_key_value_extractor_tb;
	import jkve_pkg::*;

	localparam int ITEM_TARGET    = 700;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 16;
	localparam int WATCHDOG_LIMIT = 5000;
	// Index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef enum logic [2:0] {
		SEEK_KEY, SEEK_COLON, SEEK_OPEN, IN_VALUE, VALUE_DONE
	} scan_phase_e;

	typedef enum int {
		TXT_WELL, TXT_TRUNC, TXT_NO_COLON, TXT_NO_QUOTE, TXT_NOISE, TXT_ZEROS
	} text_kind_e;

	typedef struct packed {
		logic [1:0]        status;
		logic [7:0]        value_byte;
		logic [VLEN_W-1:0] value_length;
		logic              last_of_run;
	} extract_result_t;

	typedef struct packed {
		logic [7:0]        text_byte;
		logic              end_of_text;
		logic              typed;
		logic              has_result;
		logic [1:0]        status;
		logic [7:0]        value_byte;
		logic [VLEN_W-1:0] value_length;
	} text_row_t;

	logic clk = 1'b0;
	logic arst_n;

	jkve_text_if   text_ch ();
	jkve_cfg_if    cfg_ch ();
	jkve_result_if res_ch ();

	json_key_value_extractor dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.cfg    (cfg_ch),
		.result (res_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow of the extractor: key registers and per-text scan state
	logic [63:0]       key_low  = '0;
	logic [63:0]       key_high = '0;
	logic [4:0]        key_len  = 5'd1;
	logic [7:0]        window [MAX_KEY_BYTES];
	int                window_fill = 0;
	scan_phase_e       scan_phase  = SEEK_KEY;
	logic [VLEN_W-1:0] value_count = '0;

	extract_result_t step_results[$];
	extract_result_t pending_results[$];

	int  errors      = 0;
	int  items_sent  = 0;
	int  burst_left  = 0;
	bit  gaps_on     = 1'b1;
	bit  hold_request = 1'b0;
	int  quiet_cycles = 0;

	// Directed texts under the reset key (one zero byte)
	text_row_t directed_rows [0:24] = '{
		'{8'h41, 1'b1, 1'b1, 1'b1, ST_NOTFOUND, 8'h00, 16'd0},
		'{8'h00, 1'b1, 1'b1, 1'b1, ST_NOTFOUND, 8'h00, 16'd0},
		'{8'h00, 1'b0, 1'b1, 1'b0, ST_BYTE,     8'h00, 16'd0},
		'{8'h20, 1'b0, 1'b0, 1'b0, ST_BYTE,     8'h00, 16'd0},
		'{CH_COLON, 1'b0, 1'b0, 1'b0, ST_BYTE,  8'h00, 16'd0},
		'{8'h20, 1'b0, 1'b0, 1'b0, ST_BYTE,     8'h00, 16'd0},
		'{CH_QUOTE, 1'b0, 1'b1, 1'b0, ST_BYTE,  8'h00, 16'd0},
		'{8'hFF, 1'b0, 1'b1, 1'b1, ST_BYTE,     8'hFF, 16'd1},
		'{8'h00, 1'b0, 1'b1, 1'b1, ST_BYTE,     8'h00, 16'd2},
		'{CH_QUOTE, 1'b0, 1'b1, 1'b1, ST_FOUND, 8'h00, 16'd2},
		'{8'h78, 1'b1, 1'b1, 1'b0, ST_BYTE,     8'h00, 16'd0},
		'{8'h00, 1'b0, 1'b0, 1'b0, ST_BYTE,     8'h00, 16'd0},
		'{CH_COLON, 1'b0, 1'b0, 1'b0, ST_BYTE,  8'h00, 16'd0},
		'{CH_QUOTE, 1'b0, 1'b0, 1'b0, ST_BYTE,  8'h00, 16'd0},
		'{8'h80, 1'b1, 1'b0, 1'b0, ST_BYTE,     8'h00, 16'd0},
		'{8'h00, 1'b0, 1'b0, 1'b0, ST_BYTE,     8'h00, 16'd0},
		'{CH_QUOTE, 1'b0, 1'b0, 1'b0, ST_BYTE,  8'h00, 16'd0},
		'{8'h41, 1'b1, 1'b1, 1'b1, ST_NOTFOUND, 8'h00, 16'd0},
		'{8'h00, 1'b0, 1'b0, 1'b0, ST_BYTE,     8'h00, 16'd0},
		'{CH_COLON, 1'b0, 1'b0, 1'b0, ST_BYTE,  8'h00, 16'd0},
		'{8'h41, 1'b1, 1'b1, 1'b1, ST_NOTFOUND, 8'h00, 16'd0},
		'{8'h00, 1'b0, 1'b0, 1'b0, ST_BYTE,     8'h00, 16'd0},
		'{CH_COLON, 1'b0, 1'b0, 1'b0, ST_BYTE,  8'h00, 16'd0},
		'{CH_QUOTE, 1'b0, 1'b0, 1'b0, ST_BYTE,  8'h00, 16'd0},
		'{CH_QUOTE, 1'b1, 1'b1, 1'b1, ST_FOUND, 8'h00, 16'd0}
	};

	// Key length in use: zero acts as one, anything past the window as the window
	function automatic int key_width();
		int l;
		l = key_len;
		if (l == 0) l = 1;
		if (l > MAX_KEY_BYTES) l = MAX_KEY_BYTES;
		return l;
	endfunction

	function automatic logic [7:0] key_char(input int k);
		if (k < 8) return key_low[8*k +: 8];
		return key_high[8*(k-8) +: 8];
	endfunction

	function automatic bit key_in_window();
		int l;
		int k;
		l = key_width();
		if (window_fill < l) return 1'b0;
		for (k = 0; k < l; k++)
			if (window[l-1-k] != key_char(k)) return 1'b0;
		return 1'b1;
	endfunction

	function automatic void emit(input logic [1:0] st, input logic [7:0] b);
		step_results.push_back('{status: st, value_byte: b, value_length: value_count,
			last_of_run: 1'b0});
	endfunction

	// Advance the shadow by one text byte and collect the results it causes
	function automatic void scan_byte(input logic [7:0] b, input logic eot);
		int i;
		step_results.delete();
		for (i = MAX_KEY_BYTES - 1; i > 0; i--) window[i] = window[i-1];
		window[0] = b;
		if (window_fill < MAX_KEY_BYTES) window_fill++;
		case (scan_phase)
			SEEK_KEY: begin
				if (key_in_window()) scan_phase = SEEK_COLON;
			end
			SEEK_COLON: begin
				if (b == CH_COLON) scan_phase = SEEK_OPEN;
			end
			SEEK_OPEN: begin
				if (b == CH_QUOTE) scan_phase = IN_VALUE;
			end
			IN_VALUE: begin
				if (b == CH_QUOTE) begin
					emit(ST_FOUND, 8'h00);
					scan_phase = VALUE_DONE;
				end else begin
					if (value_count < COUNT_LIMIT) value_count++;
					emit(ST_BYTE, b);
				end
			end
			default: ;
		endcase
		// End of text: report an incomplete value, then start afresh
		if (eot) begin
			if (scan_phase == IN_VALUE) emit(ST_UNTERM, 8'h00);
			else if (scan_phase != VALUE_DONE) emit(ST_NOTFOUND, 8'h00);
			for (i = 0; i < MAX_KEY_BYTES; i++) window[i] = 8'h00;
			window_fill = 0;
			scan_phase  = SEEK_KEY;
			value_count = '0;
		end
		if (step_results.size() > 0) step_results[step_results.size()-1].last_of_run = 1'b1;
	endfunction

	function automatic logic [63:0] random_key_word();
		logic [63:0] w;
		bit          letters;
		int          i;
		letters = $urandom_range(0, 1);
		for (i = 0; i < 8; i++)
			w[8*i +: 8] = letters ? 8'($urandom_range(8'h61, 8'h7A)) : 8'($urandom_range(0, 255));
		return w;
	endfunction

	function automatic logic [7:0] value_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
		return c;
	endfunction

	function automatic logic [7:0] filler_char();
		return ($urandom_range(0, 3) != 0) ? 8'h20 : 8'($urandom_range(0, 255));
	endfunction

	// Offer one byte, in bursts with gaps when gaps_on is set, and return at the edge that takes it
	task automatic send_text_byte(input logic [7:0] b, input logic eot);
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if (gaps_on) begin
				text_ch.valid = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		burst_left--;
		text_ch.valid       = 1'b1;
		text_ch.text_byte   = b;
		text_ch.end_of_text = eot;
		do @(posedge clk); while (!text_ch.ready);
		items_sent++;
	endtask

	task automatic feed_byte(input logic [7:0] b, input logic eot);
		send_text_byte(b, eot);
		scan_byte(b, eot);
		foreach (step_results[i]) pending_results.push_back(step_results[i]);
	endtask

	// Hold the sender until every result is back and the pipeline is quiet
	task automatic drain_results();
		@(negedge clk);
		text_ch.valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		@(negedge clk);
		text_ch.valid = 1'b0;
		cfg_ch.valid  = 1'b1;
		cfg_ch.index  = idx;
		cfg_ch.data   = data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_KEY_LOW:  key_low  = data;
			REG_KEY_HIGH: key_high = data;
			REG_KEY_LEN:  key_len  = data[KEY_LEN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Build one text around the current key and stream it
	task automatic send_json_text(input text_kind_e kind, input int vlen);
		logic [7:0] text_q[$];
		int         n;
		int         k;
		int         cut;
		n = (vlen < 0) ? $urandom_range(0, 8) : vlen;
		if (kind == TXT_NOISE) begin
			repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
		end else if (kind == TXT_ZEROS) begin
			repeat ($urandom_range(1, 18)) text_q.push_back(8'h00);
			text_q.push_back(CH_COLON);
			text_q.push_back(CH_QUOTE);
			text_q.push_back(value_char());
			text_q.push_back(CH_QUOTE);
		end else begin
			repeat ($urandom_range(0, 5)) text_q.push_back(8'($urandom_range(0, 255)));
			for (k = 0; k < key_width(); k++) text_q.push_back(key_char(k));
			repeat ($urandom_range(0, 2)) text_q.push_back(filler_char());
			if (kind != TXT_NO_COLON) text_q.push_back(CH_COLON);
			repeat ($urandom_range(0, 2)) text_q.push_back(filler_char());
			if (kind != TXT_NO_QUOTE) text_q.push_back(CH_QUOTE);
			repeat (n) text_q.push_back(value_char());
			text_q.push_back(CH_QUOTE);
			repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range(0, 255)));
			if (kind == TXT_TRUNC) begin
				cut = $urandom_range(1, text_q.size());
				while (text_q.size() > cut) void'(text_q.pop_back());
			end
		end
		foreach (text_q[i]) feed_byte(text_q[i], i == text_q.size() - 1);
	endtask

	function automatic text_kind_e pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return TXT_WELL;
		if (r < 72) return TXT_TRUNC;
		if (r < 80) return TXT_NO_COLON;
		if (r < 86) return TXT_NO_QUOTE;
		if (r < 94) return TXT_NOISE;
		return TXT_ZEROS;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// Compare each result transfer with the oldest outstanding expectation
	always @(posedge clk) begin : result_check
		extract_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d byte %0h length %0d",
					res_ch.status, res_ch.value_byte, res_ch.value_length);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 16'(want.status), 16'(res_ch.status));
				check_field("value_byte", 16'(want.value_byte), 16'(res_ch.value_byte));
				check_field("value_length", want.value_length, res_ch.value_length);
				check_field("last_of_run", 16'(want.last_of_run), 16'(res_ch.last_of_run));
			end
		end
	end

	// Give up when no channel has moved for too long
	always @(posedge clk) begin
		if (!arst_n || (text_ch.valid && text_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Result receiver: changing stall patterns, plus a long hold-off on request
	initial begin : result_sink
		int mode;
		int span;
		int beat;
		beat = 0;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 200);
			repeat (span) begin
				@(negedge clk);
				if (hold_request) begin
					hold_request = 1'b0;
					res_ch.ready = 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
				end
				beat++;
				case (mode)
					0: res_ch.ready = 1'b1;
					1: res_ch.ready = $urandom_range(0, 1);
					2: res_ch.ready = ($urandom_range(0, 3) != 0);
					default: res_ch.ready = (beat % 3 == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		logic [63:0] len_data;
		int          len_plan [5];
		int          phase_no;
		int          phase_end;
		int          r;
		len_plan = '{16, 1, 0, 31, 17};
		for (r = 0; r < MAX_KEY_BYTES; r++) window[r] = 8'h00;
		arst_n              = 1'b0;
		text_ch.valid       = 1'b0;
		text_ch.text_byte   = 8'h00;
		text_ch.end_of_text = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = REG_KEY_LOW;
		cfg_ch.data         = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table: typed rows carry their own expectation
		foreach (directed_rows[i]) begin
			send_text_byte(directed_rows[i].text_byte, directed_rows[i].end_of_text);
			scan_byte(directed_rows[i].text_byte, directed_rows[i].end_of_text);
			if (directed_rows[i].typed) begin
				if (directed_rows[i].has_result)
					pending_results.push_back('{status: directed_rows[i].status,
						value_byte: directed_rows[i].value_byte,
						value_length: directed_rows[i].value_length, last_of_run: 1'b1});
			end else begin
				foreach (step_results[j]) pending_results.push_back(step_results[j]);
			end
		end
		drain_results();
		write_reg(REG_SPARE, {$urandom(), $urandom()});

		// Random phases, each under a fresh key; the first uses an all-zero key
		items_sent = 0;
		phase_no   = 0;
		while (items_sent < ITEM_TARGET) begin
			drain_results();
			if (phase_no == 0) begin
				write_reg(REG_KEY_LOW, '0);
				write_reg(REG_KEY_HIGH, '0);
			end else begin
				write_reg(REG_KEY_LOW, random_key_word());
				write_reg(REG_KEY_HIGH, random_key_word());
			end
			len_data      = {$urandom(), $urandom()};
			len_data[4:0] = (phase_no < 5) ? 5'(len_plan[phase_no]) : 5'($urandom_range(1, 16));
			write_reg(REG_KEY_LEN, len_data);
			gaps_on   = ($urandom_range(0, 3) != 0);
			phase_end = items_sent + $urandom_range(50, 90);
			if (phase_no == 2) begin
				// Stall the receiver long enough for the block to back up
				hold_request = 1'b1;
				send_json_text(TXT_WELL, 40);
				drain_results();
			end
			while (items_sent < phase_end) begin
				send_json_text(pick_kind(), -1);
				if ($urandom_range(0, 9) == 0) drain_results();
			end
			phase_no++;
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
